/* rtl/palloc_pkg.sv */
// ----------------------------------------------------------------------------
// palloc_pkg
// Shared constants and types of the placement allocator with reserved gaps.
// ----------------------------------------------------------------------------
package palloc_pkg;

  localparam int GAP_SLOTS = 32;                 // gap table depth
  localparam int IDX_W     = $clog2(GAP_SLOTS);  // gap index and gap count width
  localparam int ADDR_W    = 32;
  localparam int GAP_W     = 2 * ADDR_W;         // one gap entry: {end, start}

  localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hFFFF_F000;
  localparam logic [ADDR_W-1:0] PAGE_SIZE = 32'h0000_1000;
  localparam logic [ADDR_W-1:0] OFFS_MASK = 32'h0000_0FFF;

  typedef enum logic [1:0] {
    REQ_ADD_GAP = 2'd0,
    REQ_INIT    = 2'd1,
    REQ_ALLOC   = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OOM  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_COMMIT,
    S_FINISH
  } state_t;

endpackage

/* rtl/palloc_if.sv */
// ----------------------------------------------------------------------------
// palloc_in_if / palloc_out_if
// Valid/ready channels for requests and results of the placement allocator.
// ----------------------------------------------------------------------------
interface palloc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] lower_addr;
  logic [31:0] upper_addr;
  logic [31:0] alloc_size;
  logic        page_align;

  modport source (output valid, req_type, lower_addr, upper_addr, alloc_size, page_align,
                  input ready);
  modport sink   (input valid, req_type, lower_addr, upper_addr, alloc_size, page_align,
                  output ready);
endinterface

interface palloc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] alloc_addr;
  logic [31:0] total_allocs;
  logic [31:0] total_bytes;

  modport source (output valid, status, alloc_addr, total_allocs, total_bytes,
                  input ready);
  modport sink   (input valid, status, alloc_addr, total_allocs, total_bytes,
                  output ready);
endinterface

/* rtl/palloc_ram.sv */
// ----------------------------------------------------------------------------
// palloc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module palloc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/palloc_step.sv */
// ----------------------------------------------------------------------------
// palloc_step
// Shared pointer update: bump past one gap, then, when enabled, round up to a page boundary.
// ----------------------------------------------------------------------------
module palloc_step (
  input  logic [palloc_pkg::ADDR_W-1:0] ptr_in,
  input  logic [palloc_pkg::ADDR_W-1:0] gap_start,
  input  logic [palloc_pkg::ADDR_W-1:0] gap_end,
  input  logic                          skip_en,
  input  logic                          align_en,
  output logic [palloc_pkg::ADDR_W-1:0] ptr_out
);

  logic                          hit;
  logic [palloc_pkg::ADDR_W-1:0] bumped;

  always_comb begin
    // a reversed gap never matches since both compares cannot hold
    hit    = skip_en && (ptr_in >= gap_start) && (ptr_in <= gap_end);
    bumped = hit ? gap_end + palloc_pkg::ADDR_W'(1) : ptr_in;
    if (align_en && ((bumped & palloc_pkg::OFFS_MASK) != '0)) begin
      ptr_out = (bumped & palloc_pkg::PAGE_MASK) + palloc_pkg::PAGE_SIZE;
    end else begin
      ptr_out = bumped;
    end
  end

endmodule

/* rtl/placement_allocator_with_gaps_core.sv */
// ----------------------------------------------------------------------------
// placement_allocator_with_gaps_core
// Bump-pointer allocator that steps over a table of reserved address gaps.
// ----------------------------------------------------------------------------
// Handles one request at a time. An add-gap or unused-code request goes straight to the
// finish state; an initialize request walks the gap table and then checks,
// and an allocate request walks, checks and commits, before the finish state
// hands the result over and the block is ready again; gap_count is 0 skips the walk.
// The request time grows with the gap walk: one shared skip/align unit visits one
// stored gap per cycle (up to 31 in a full table), fed from the gap RAM's single registered read port.
// A finished result sits in the output register, so the next request can be
// taken while the previous result is still waiting to be consumed.
module placement_allocator_with_gaps_core (
  input  logic                clk,
  input  logic                rst_n,
  palloc_in_if.sink           in_chan,
  palloc_out_if.source        out_chan
);

  localparam int AW = palloc_pkg::ADDR_W;
  localparam int IW = palloc_pkg::IDX_W;

  palloc_pkg::state_t state_r, state_nxt;

  // allocator state
  logic [AW-1:0] next_addr_r, next_addr_nxt;
  logic [AW-1:0] region_end_r, region_end_nxt;
  logic [IW-1:0] gap_count_r, gap_count_nxt;
  logic [AW-1:0] alloc_cnt_r, alloc_cnt_nxt;
  logic [AW-1:0] byte_cnt_r, byte_cnt_nxt;

  // request in flight
  logic [1:0]    req_r, req_nxt;
  logic [AW-1:0] upper_r, upper_nxt;
  logic [AW-1:0] size_r, size_nxt;
  logic          align_r, align_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [AW:0]   sum_r, sum_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [AW-1:0] res_addr_r, res_addr_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [AW-1:0] out_addr_r, out_addr_nxt;
  logic [AW-1:0] out_allocs_r, out_allocs_nxt;
  logic [AW-1:0] out_bytes_r, out_bytes_nxt;

  // gap RAM
  logic                               ram_we;
  logic [IW-1:0]                      ram_raddr;
  logic [palloc_pkg::GAP_W-1:0]       ram_wdata;
  logic [palloc_pkg::GAP_W-1:0]       ram_rdata;

  // shared step unit
  logic [AW-1:0] step_in, step_out;
  logic          step_skip, step_align;

  logic in_fire;
  logic out_free;
  logic walk_last;
  logic gap_full;

  assign in_fire   = in_chan.valid && in_chan.ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign walk_last = (idx_r == gap_count_r - IW'(1));
  assign gap_full  = (gap_count_r == IW'(palloc_pkg::GAP_SLOTS - 1));

  assign in_chan.ready         = (state_r == palloc_pkg::S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.alloc_addr   = out_addr_r;
  assign out_chan.total_allocs = out_allocs_r;
  assign out_chan.total_bytes  = out_bytes_r;

  // read gap 0 while idle so it is ready on the first walk cycle
  assign ram_raddr = (state_r == palloc_pkg::S_WALK) ? idx_r + IW'(1) : '0;
  assign ram_we    = in_fire && (in_chan.req_type == palloc_pkg::REQ_ADD_GAP) && !gap_full;
  assign ram_wdata = {in_chan.upper_addr, in_chan.lower_addr};

  palloc_ram #(
    .WIDTH (palloc_pkg::GAP_W),
    .DEPTH (palloc_pkg::GAP_SLOTS)
  ) u_gap_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (gap_count_r),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    if (state_r == palloc_pkg::S_WALK) begin
      step_in    = ptr_r;
      step_skip  = 1'b1;
      step_align = align_r;
    end else begin
      step_in    = next_addr_r;
      step_skip  = 1'b0;
      step_align = (in_chan.req_type == palloc_pkg::REQ_ALLOC) && in_chan.page_align;
    end
  end

  palloc_step u_step (
    .ptr_in    (step_in),
    .gap_start (ram_rdata[AW-1:0]),
    .gap_end   (ram_rdata[palloc_pkg::GAP_W-1:AW]),
    .skip_en   (step_skip),
    .align_en  (step_align),
    .ptr_out   (step_out)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      palloc_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((in_chan.req_type == palloc_pkg::REQ_INIT ||
               in_chan.req_type == palloc_pkg::REQ_ALLOC) && gap_count_r != '0) begin
            state_nxt = palloc_pkg::S_WALK;
          end else if (in_chan.req_type == palloc_pkg::REQ_INIT ||
                       in_chan.req_type == palloc_pkg::REQ_ALLOC) begin
            state_nxt = palloc_pkg::S_CHECK;
          end else begin
            state_nxt = palloc_pkg::S_FINISH;
          end
        end
      end
      palloc_pkg::S_WALK: begin
        if (walk_last) begin
          state_nxt = palloc_pkg::S_CHECK;
        end
      end
      palloc_pkg::S_CHECK: begin
        if (req_r == palloc_pkg::REQ_ALLOC) begin
          state_nxt = palloc_pkg::S_COMMIT;
        end else begin
          state_nxt = palloc_pkg::S_FINISH;
        end
      end
      palloc_pkg::S_COMMIT: begin
        state_nxt = palloc_pkg::S_FINISH;
      end
      palloc_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = palloc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = palloc_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    next_addr_nxt  = next_addr_r;
    region_end_nxt = region_end_r;
    gap_count_nxt  = gap_count_r;
    alloc_cnt_nxt  = alloc_cnt_r;
    byte_cnt_nxt   = byte_cnt_r;
    req_nxt        = req_r;
    upper_nxt      = upper_r;
    size_nxt       = size_r;
    align_nxt      = align_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    sum_nxt        = sum_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_allocs_nxt = out_allocs_r;
    out_bytes_nxt  = out_bytes_r;

    case (state_r)
      palloc_pkg::S_IDLE: begin
        if (in_fire) begin
          req_nxt        = in_chan.req_type;
          upper_nxt      = in_chan.upper_addr;
          size_nxt       = in_chan.alloc_size;
          align_nxt      = (in_chan.req_type == palloc_pkg::REQ_ALLOC) && in_chan.page_align;
          idx_nxt        = '0;
          res_status_nxt = palloc_pkg::STAT_OK;
          res_addr_nxt   = '0;
          ptr_nxt        = (in_chan.req_type == palloc_pkg::REQ_INIT) ? in_chan.lower_addr
                                                                      : step_out;
          if (in_chan.req_type == palloc_pkg::REQ_ADD_GAP) begin
            if (gap_full) begin
              res_status_nxt = palloc_pkg::STAT_FULL;
            end else begin
              gap_count_nxt = gap_count_r + IW'(1);
            end
          end
        end
      end
      palloc_pkg::S_WALK: begin
        ptr_nxt = step_out;
        idx_nxt = idx_r + IW'(1);
      end
      palloc_pkg::S_CHECK: begin
        if (req_r == palloc_pkg::REQ_INIT) begin
          next_addr_nxt  = ptr_r;
          region_end_nxt = upper_r;
        end else begin
          sum_nxt = {1'b0, ptr_r} + {1'b0, size_r};
        end
      end
      palloc_pkg::S_COMMIT: begin
        if (sum_r >= {1'b0, region_end_r}) begin
          res_status_nxt = palloc_pkg::STAT_OOM;
        end else begin
          // padding and skipped gaps count toward the byte total
          res_addr_nxt  = ptr_r;
          byte_cnt_nxt  = byte_cnt_r + sum_r[AW-1:0] - next_addr_r;
          next_addr_nxt = sum_r[AW-1:0];
          alloc_cnt_nxt = alloc_cnt_r + AW'(1);
        end
      end
      palloc_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_allocs_nxt = alloc_cnt_r;
          out_bytes_nxt  = byte_cnt_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= palloc_pkg::S_IDLE;
      next_addr_r  <= '0;
      region_end_r <= '0;
      gap_count_r  <= '0;
      alloc_cnt_r  <= '0;
      byte_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_addr_r  <= next_addr_nxt;
      region_end_r <= region_end_nxt;
      gap_count_r  <= gap_count_nxt;
      alloc_cnt_r  <= alloc_cnt_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    upper_r      <= upper_nxt;
    size_r       <= size_nxt;
    align_r      <= align_nxt;
    ptr_r        <= ptr_nxt;
    idx_r        <= idx_nxt;
    sum_r        <= sum_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_allocs_r <= out_allocs_nxt;
    out_bytes_r  <= out_bytes_nxt;
  end

endmodule

/* dv/placement_allocator_with_gaps_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// placement_allocator_with_gaps_core_tb
// Drives gap, initialize, allocate and unused-code requests into the placement
// allocator and checks every reply field against typed-in expectations or an
// in-bench model of the allocator: a short table of hand-picked requests first,
// then constrained-random traffic under several flow-control mixes on both channels.
// ----------------------------------------------------------------------------
module placement_allocator_with_gaps_core_tb;

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int          RANDOM_ITEMS = 1580;
  localparam logic [31:0] WIN_BASE     = 32'h2000_0000;
  localparam logic [31:0] WIN_SPAN     = 32'h0010_0000;
  localparam int          TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] size;
    logic        align;
  } alloc_req_t;

  typedef struct packed {
    palloc_pkg::status_t status;
    logic [31:0]         addr;
    logic [31:0]         allocs;
    logic [31:0]         bytes;
  } alloc_reply_t;

  typedef struct packed {
    alloc_req_t   rq;
    bit           typed;
    alloc_reply_t reply;
  } stim_row_t;

  logic clk;
  logic rst_n;

  palloc_in_if  in_ch ();
  palloc_out_if out_ch ();

  placement_allocator_with_gaps_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // Allocator shadow state
  logic [31:0]  next_ptr;
  logic [31:0]  region_limit;
  logic [31:0]  gap_lo [palloc_pkg::GAP_SLOTS];
  logic [31:0]  gap_hi [palloc_pkg::GAP_SLOTS];
  int unsigned  gap_num;
  logic [31:0]  grant_count;
  logic [31:0]  consumed_bytes;

  alloc_reply_t replies_due[$];
  stim_row_t    directed_rows[$];
  alloc_reply_t want;

  int src_idle_pct;
  int sink_stall_pct;
  int err_count;
  int replies_checked;
  int oom_seen;
  int full_seen;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic log_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [31:0] page_round(logic [31:0] p, logic want_align);
    if (want_align && (p & palloc_pkg::OFFS_MASK) != '0) begin
      return (p & palloc_pkg::PAGE_MASK) + palloc_pkg::PAGE_SIZE;
    end
    return p;
  endfunction

  function automatic logic [31:0] step_over_gap(logic [31:0] p, int k);
    if (p >= gap_lo[k] && p <= gap_hi[k]) begin
      return gap_hi[k] + 32'd1;
    end
    return p;
  endfunction

  // Advance the shadow state by one request and return the reply it earns.
  function automatic alloc_reply_t allocator_reply(alloc_req_t rq);
    alloc_reply_t r;
    logic [31:0]  p;
    logic [31:0]  np;
    int           k;
    r.status = palloc_pkg::STAT_OK;
    r.addr   = '0;
    case (rq.req)
      palloc_pkg::REQ_ADD_GAP: begin
        if (gap_num >= palloc_pkg::GAP_SLOTS - 1) begin
          r.status = palloc_pkg::STAT_FULL;
        end else begin
          gap_lo[gap_num] = rq.lo;
          gap_hi[gap_num] = rq.hi;
          gap_num++;
        end
      end
      palloc_pkg::REQ_INIT: begin
        p = rq.lo;
        for (k = 0; k < gap_num; k++) p = step_over_gap(p, k);
        next_ptr     = p;
        region_limit = rq.hi;
      end
      palloc_pkg::REQ_ALLOC: begin
        p = page_round(next_ptr, rq.align);
        for (k = 0; k < gap_num; k++) p = page_round(step_over_gap(p, k), rq.align);
        if (({1'b0, p} + {1'b0, rq.size}) >= {1'b0, region_limit}) begin
          r.status = palloc_pkg::STAT_OOM;
        end else begin
          np             = p + rq.size;
          r.addr         = p;
          consumed_bytes = consumed_bytes + (np - next_ptr);
          next_ptr       = np;
          grant_count    = grant_count + 32'd1;
        end
      end
      default: ;
    endcase
    r.allocs = grant_count;
    r.bytes  = consumed_bytes;
    return r;
  endfunction

  task automatic add_row(logic [1:0] req, logic [31:0] lo, logic [31:0] hi,
                         logic [31:0] size, logic align, bit typed,
                         palloc_pkg::status_t st = palloc_pkg::STAT_OK,
                         logic [31:0] addr = '0,
                         logic [31:0] allocs = '0, logic [31:0] bytes = '0);
    stim_row_t row;
    row.rq           = '{req: req, lo: lo, hi: hi, size: size, align: align};
    row.typed        = typed;
    row.reply.status = st;
    row.reply.addr   = addr;
    row.reply.allocs = allocs;
    row.reply.bytes  = bytes;
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(alloc_req_t rq, bit typed, alloc_reply_t typed_reply);
    alloc_reply_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= rq.req;
    in_ch.lower_addr <= rq.lo;
    in_ch.upper_addr <= rq.hi;
    in_ch.alloc_size <= rq.size;
    in_ch.page_align <= rq.align;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = allocator_reply(rq);
    replies_due.push_back(typed ? typed_reply : pred);
    @(negedge clk);
  endtask

  // Result side: random backpressure, updated on the falling edge.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (replies_due.size() == 0) begin
        log_mismatch($sformatf("reply with nothing outstanding: status %0d addr %h",
                               out_ch.status, out_ch.alloc_addr));
      end else begin
        want = replies_due.pop_front();
        replies_checked++;
        if (want.status == palloc_pkg::STAT_OOM)  oom_seen++;
        if (want.status == palloc_pkg::STAT_FULL) full_seen++;
        if (out_ch.status !== want.status)
          log_mismatch($sformatf("status got %0d expected %0d", out_ch.status, want.status));
        if (out_ch.alloc_addr !== want.addr)
          log_mismatch($sformatf("alloc_addr got %h expected %h", out_ch.alloc_addr, want.addr));
        if (out_ch.total_allocs !== want.allocs)
          log_mismatch($sformatf("total_allocs got %h expected %h",
                                 out_ch.total_allocs, want.allocs));
        if (out_ch.total_bytes !== want.bytes)
          log_mismatch($sformatf("total_bytes got %h expected %h",
                                 out_ch.total_bytes, want.bytes));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Watchdog expired with %0d replies outstanding", replies_due.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    alloc_req_t   rq;
    alloc_reply_t none;
    logic [31:0]  a;
    logic [31:0]  b;
    int           counted;
    int           phase;
    int           pick;
    int           kind;

    none            = '0;
    err_count       = 0;
    replies_checked = 0;
    oom_seen        = 0;
    full_seen       = 0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    next_ptr        = '0;
    region_limit    = '0;
    gap_num         = 0;
    grant_count     = '0;
    consumed_bytes  = '0;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= palloc_pkg::REQ_ADD_GAP;
    in_ch.lower_addr <= '0;
    in_ch.upper_addr <= '0;
    in_ch.alloc_size <= '0;
    in_ch.page_align <= 1'b0;

    // Hand-picked requests; expectations typed in where they are obvious.
    add_row(palloc_pkg::REQ_ALLOC, '0, '0, '0, 1'b0, 1, palloc_pkg::STAT_OOM);  // empty region
    add_row(REQ_UNUSED, '1, '1, '1, 1'b1, 1, palloc_pkg::STAT_OK);              // unused code
    add_row(palloc_pkg::REQ_INIT, '0, '1, '0, 1'b0, 1, palloc_pkg::STAT_OK);
    add_row(palloc_pkg::REQ_ALLOC, '0, '0, 32'h10, 1'b0, 1, palloc_pkg::STAT_OK, '0, 32'd1,
            32'h10);
    add_row(palloc_pkg::REQ_ALLOC, '0, '0, 32'h1, 1'b1, 1, palloc_pkg::STAT_OK, 32'h1000,
            32'd2, 32'h1001);
    add_row(palloc_pkg::REQ_ALLOC, '0, '0, '1, 1'b0, 1, palloc_pkg::STAT_OOM, '0, 32'd2,
            32'h1001);
    add_row(palloc_pkg::REQ_INIT, 32'hFFFF_F001, '1, '0, 1'b0, 1, palloc_pkg::STAT_OK, '0,
            32'd2, 32'h1001);
    // top page aligns around to zero
    add_row(palloc_pkg::REQ_ALLOC, '0, '0, '0, 1'b1, 1, palloc_pkg::STAT_OK, '0, 32'd3,
            32'h2000);
    add_row(palloc_pkg::REQ_ADD_GAP, 32'h2000_0000, 32'h2000_0FFF, '0, 1'b0, 1,
            palloc_pkg::STAT_OK, '0, 32'd3, 32'h2000);
    add_row(palloc_pkg::REQ_ADD_GAP, '1, '0, '0, 1'b0, 1, palloc_pkg::STAT_OK, '0, 32'd3,
            32'h2000);                                                          // reversed
    add_row(palloc_pkg::REQ_INIT,    32'h2000_0800, 32'h2001_0000, '0, 1'b0, 0);
    add_row(palloc_pkg::REQ_ADD_GAP, 32'h2000_1000, 32'h2000_17FF, '0, 1'b0, 0);
    add_row(palloc_pkg::REQ_ALLOC,   '0, '0, 32'h100, 1'b1, 0);
    add_row(palloc_pkg::REQ_ALLOC,   '0, '0, 32'h100, 1'b0, 0);
    add_row(palloc_pkg::REQ_ADD_GAP, 32'hFFFF_F000, '1, '0, 1'b0, 0);   // skip wraps to zero
    add_row(palloc_pkg::REQ_INIT,    32'hFFFF_F800, 32'h0000_8000, '0, 1'b0, 0);
    add_row(palloc_pkg::REQ_ALLOC,   '0, '0, 32'h7FFF, 1'b0, 0);
    add_row(palloc_pkg::REQ_ALLOC,   '0, '0, '0, 1'b0, 0);
    add_row(palloc_pkg::REQ_ALLOC,   '0, '0, 32'h1, 1'b0, 0);            // end hit exactly
    add_row(palloc_pkg::REQ_ALLOC,   '1, '1, '0, 1'b1, 0);
    add_row(palloc_pkg::REQ_INIT,    32'h2000_0000, 32'h2000_0000, '0, 1'b0, 0);  // chained
    add_row(palloc_pkg::REQ_ALLOC,   '0, '0, '0, 1'b1, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].reply);
    end

    counted = 0;
    phase   = -1;
    while (counted < RANDOM_ITEMS) begin
      if (counted * 4 / RANDOM_ITEMS != phase) begin
        // drain completely before switching the flow-control mix
        phase = counted * 4 / RANDOM_ITEMS;
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (replies_due.size() != 0);
        case (phase)
          0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
          1:       begin src_idle_pct = 79; sink_stall_pct = 0;  end
          2:       begin src_idle_pct = 0;  sink_stall_pct = 79; end
          default: begin src_idle_pct = 8;  sink_stall_pct = 8;  end
        endcase
      end

      pick     = int'($urandom_range(0, 99));
      kind     = int'($urandom_range(0, 99));
      rq.align = 1'($urandom_range(0, 1));
      rq.lo    = $urandom;
      rq.hi    = $urandom;
      rq.size  = $urandom;
      if (pick < 6) begin
        rq.req = palloc_pkg::REQ_ADD_GAP;
        if (kind < 80) begin
          rq.lo = WIN_BASE + $urandom_range(0, WIN_SPAN - 1);
          rq.hi = rq.lo + $urandom_range(0, 32'h3FFF);
        end else if (kind < 92) begin
          a     = $urandom;
          b     = $urandom;
          rq.lo = (a > b) ? a : b;
          rq.hi = (a > b) ? b : a;
        end else begin
          rq.lo = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
          rq.hi = '1;
        end
      end else if (pick < 14) begin
        rq.req = palloc_pkg::REQ_INIT;
        if (kind < 80) begin
          rq.lo = WIN_BASE + $urandom_range(0, WIN_SPAN - 1);
          rq.hi = rq.lo + $urandom_range(0, 32'h0004_0000);
        end else if (kind < 88) begin
          rq.lo = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
        end
      end else if (pick < 17) begin
        rq.req = REQ_UNUSED;
      end else begin
        rq.req = palloc_pkg::REQ_ALLOC;
        if (kind < 85) begin
          rq.size = $urandom_range(0, 32'h1FFF);
        end else if (kind < 95) begin
          rq.size = $urandom_range(0, 32'h3_0000);
        end
      end

      send_request(rq, 0, none);
      if (rq.req != REQ_UNUSED) counted++;
    end

    in_ch.valid <= 1'b0;
    do @(negedge clk); while (replies_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d replies: %0d grants, %0d out of memory, %0d gap table full",
             replies_checked, grant_count, oom_seen, full_seen);
    $display("Gap table ended with %0d entries; flow mixes: none, sender, receiver, both",
             gap_num);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
